@@ rtl/core/iskl_pkg.sv @@
// Shared constants and types for the infostring key lookup block.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package iskl_pkg;

    localparam int KEY_MAX_BYTES = 16;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
    localparam logic [7:0] CHAR_NUL       = 8'h00;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        CFG_KEY_LOW  = 2'd0,
        CFG_KEY_HIGH = 2'd1,
        CFG_KEY_LEN  = 2'd2,
        CFG_CAPACITY = 2'd3
    } cfg_index_t;

    // Outcome reported on the final item of a string.
    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_BAD_KEY   = 2'd2,
        ST_NO_ROOM   = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] value_byte;
        logic       is_final;
        status_t    status;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/infostring_key_lookup_top.sv @@
// Infostring key lookup: top level with parser, configuration registers and output buffer.
// Depends on iskl_pkg.
`default_nettype none

// Takes one string byte per cycle on the input channel while in_ready is high, with no
// bubbles between strings: each byte is parsed by a registered state update, and its
// value byte or final status, if it yields one, lands in the output register or the skid
// entry. A two-entry output buffer lets the block take a new item while a finished result
// still waits, so in_ready only drops when both output entries are held. Configuration
// writes are accepted every cycle; write only while no string is in progress.
module infostring_key_lookup_top (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [63:0]          cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           text_byte,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [7:0]                value_byte,
    output logic                      is_final,
    output iskl_pkg::status_t         status
);
    import iskl_pkg::*;

    typedef enum logic [2:0] {
        PH_START,
        PH_KEY,
        PH_VSKIP,
        PH_VCOPY,
        PH_DONE
    } phase_t;

    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;
    logic [4:0]  key_len_reg;
    logic [7:0]  capacity_reg;

    phase_t      phase_reg, phase_next;
    logic [4:0]  match_pos_reg, match_pos_next;
    logic        matching_reg, matching_next;
    logic [7:0]  copied_reg, copied_next;
    logic        found_reg, found_next;

    result_t     out_data_reg, skid_data_reg, res;
    logic        out_valid_reg, skid_valid_reg;
    logic        res_valid;

    logic [127:0] key_word;
    logic [7:0]   key_cur;
    logic         key_bad;
    logic         no_room;
    logic         key_complete;
    logic         accept;
    logic         pop;
    logic         push;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= '0;
            capacity_reg <= 8'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                CFG_KEY_HIGH: key_high_reg <= cfg_data;
                CFG_KEY_LEN:  key_len_reg  <= cfg_data[4:0];
                CFG_CAPACITY: capacity_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign key_word = {key_high_reg, key_low_reg};
    assign key_cur  = key_word[{match_pos_reg[3:0], 3'b000} +: 8];
    assign no_room  = (capacity_reg == 8'd0);
    assign key_complete = matching_reg && (match_pos_reg == key_len_reg);

    // Key validity is recomputed every cycle from the registers.
    always_comb
    begin
        key_bad = (key_len_reg == 5'd0) || (key_len_reg > 5'(KEY_MAX_BYTES));
        for (int i = 0; i < KEY_MAX_BYTES; i++)
        begin
            if ((5'(i) < key_len_reg) &&
                ((key_word[i*8 +: 8] == CHAR_BACKSLASH) ||
                 (key_word[i*8 +: 8] == CHAR_DQUOTE)))
            begin
                key_bad = 1'b1;
            end
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        match_pos_next = match_pos_reg;
        matching_next  = matching_reg;
        copied_next    = copied_reg;
        found_next     = found_reg;
        res_valid      = 1'b0;
        res.value_byte = CHAR_NUL;
        res.is_final   = 1'b0;
        res.status     = ST_FOUND;

        if (text_byte == CHAR_NUL)
        begin
            res_valid    = 1'b1;
            res.is_final = 1'b1;
            priority if (no_room)
                res.status = ST_NO_ROOM;
            else if (key_bad)
                res.status = ST_BAD_KEY;
            else if (found_reg || ((phase_reg == PH_KEY) && key_complete))
                res.status = ST_FOUND;
            else
                res.status = ST_NOT_FOUND;
            phase_next     = PH_START;
            match_pos_next = '0;
            matching_next  = 1'b1;
            copied_next    = '0;
            found_next     = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if (text_byte == CHAR_BACKSLASH)
                    begin
                        phase_next     = PH_KEY;
                        match_pos_next = '0;
                        matching_next  = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_KEY:
                begin
                    if (text_byte == CHAR_BACKSLASH)
                    begin
                        if (key_complete)
                        begin
                            found_next  = 1'b1;
                            copied_next = '0;
                            phase_next  = PH_VCOPY;
                        end
                        else
                        begin
                            phase_next = PH_VSKIP;
                        end
                    end
                    else if (matching_reg && (match_pos_reg < key_len_reg) &&
                             (match_pos_reg < 5'(KEY_MAX_BYTES)) &&
                             (text_byte == key_cur))
                    begin
                        match_pos_next = match_pos_reg + 5'd1;
                    end
                    else
                    begin
                        matching_next = 1'b0;
                    end
                end
                PH_VSKIP:
                begin
                    if (text_byte == CHAR_BACKSLASH)
                    begin
                        phase_next     = PH_KEY;
                        match_pos_next = '0;
                        matching_next  = 1'b1;
                    end
                end
                PH_VCOPY:
                begin
                    if (text_byte == CHAR_BACKSLASH)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (!no_room && !key_bad &&
                             (({1'b0, copied_reg} + 9'd1) < {1'b0, capacity_reg}))
                    begin
                        copied_next    = copied_reg + 8'd1;
                        res_valid      = 1'b1;
                        res.value_byte = text_byte;
                    end
                end
                PH_DONE: ;
                default: ;
            endcase
        end
    end

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;
    assign pop      = out_valid_reg && out_ready;
    assign push     = accept && res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_START;
            match_pos_reg  <= '0;
            matching_reg   <= 1'b1;
            copied_reg     <= '0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            out_data_reg   <= '0;
            skid_data_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                match_pos_reg <= match_pos_next;
                matching_reg  <= matching_next;
                copied_reg    <= copied_next;
                found_reg     <= found_next;
            end
            // The skid entry is always older than anything new, so it moves up first.
            if (skid_valid_reg)
            begin
                if (pop)
                begin
                    out_data_reg   <= skid_data_reg;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (push)
            begin
                if (!out_valid_reg || pop)
                begin
                    out_data_reg  <= res;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_data_reg  <= res;
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign value_byte = out_data_reg.value_byte;
    assign is_final   = out_data_reg.is_final;
    assign status     = out_data_reg.status;

endmodule

`default_nettype wire

@@ rtl/core/iskl_checker.sv @@
// Port-level checker for the infostring key lookup top level, with its bind.
// Depends on iskl_pkg and infostring_key_lookup_top.
`default_nettype none

module iskl_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [7:0]        value_byte,
    input wire logic              is_final,
    input wire iskl_pkg::status_t status
);
    import iskl_pkg::*;

    // A stalled result item holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value_byte) &&
            $stable(is_final) && $stable(status))
    else $error("stalled result item changed");

    // Value bytes carry no status; the final item carries no byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_final |-> status == ST_FOUND)
    else $error("value byte with nonzero status");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_final |-> value_byte == 8'd0)
    else $error("final item with nonzero byte");

    // Input backpressure only appears when both output entries are held.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
    else $error("input stalled with empty output");

endmodule

bind infostring_key_lookup_top iskl_checker u_iskl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value_byte (value_byte),
    .is_final   (is_final),
    .status     (status)
);

`default_nettype wire

@@ sim/tb_infostring_key_lookup_top.sv @@
// Self-checking testbench for infostring_key_lookup_top: directed strings, then random ones.
// Depends on iskl_pkg and the RTL of the block; a built-in predictor supplies expected results.
module tb_infostring_key_lookup_top;
    import iskl_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTINGS_PER_STAGE = 6;
    localparam int BYTES_PER_SETTING = 50;

    typedef enum logic [2:0] {
        P_START,
        P_KEY,
        P_VSKIP,
        P_VCOPY,
        P_DONE
    } parse_phase_t;

    // One directed string: optional register setup, up to eight text bytes
    // (right-justified), and the outcome expected on its zero byte.
    typedef struct packed {
        logic         write_cfg;
        logic [127:0] key;
        logic [4:0]   key_len;
        logic [7:0]   capacity;
        logic [63:0]  text;
        status_t      outcome;
    } directed_string_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = CFG_KEY_LOW;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  text_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  value_byte;
    logic        is_final;
    status_t     status;

    // Predictor copy of the registers and parser state, at reset values.
    logic [63:0]  key_low_reg = '0;
    logic [63:0]  key_high_reg = '0;
    logic [4:0]   key_len_reg = '0;
    logic [7:0]   capacity_reg = 8'd1;
    parse_phase_t parse_phase = P_START;
    int           match_pos = 0;
    bit           still_match = 1'b1;
    int           copied = 0;
    bit           found = 1'b0;

    result_t          pending_lookup_results[$];
    result_t          oldest;
    directed_string_t directed_rows[10];
    int               send_idle_pct = 22;
    int               recv_idle_pct = 46;
    int               sent_bytes = 0;
    int               mismatches = 0;
    int               stall_cycles = 0;

    infostring_key_lookup_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .text_byte  (text_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value_byte (value_byte),
        .is_final   (is_final),
        .status     (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] key_char(input int i);
        logic [127:0] word;
        word = {key_high_reg, key_low_reg};
        return word[(i & 15) * 8 +: 8];
    endfunction

    function automatic bit key_rejected();
        bit bad;
        bad = (key_len_reg == 0) || (key_len_reg > KEY_MAX_BYTES);
        for (int i = 0; i < KEY_MAX_BYTES; i++)
        begin
            if (i < key_len_reg && (key_char(i) == CHAR_BACKSLASH || key_char(i) == CHAR_DQUOTE))
                bad = 1'b1;
        end
        return bad;
    endfunction

    // Any nonzero byte except the separator.
    function automatic logic [7:0] field_char();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        if (c == CHAR_BACKSLASH)
            c = CHAR_DQUOTE;
        return c;
    endfunction

    task automatic parse_text_byte(input logic [7:0] b, output bit emits, output result_t res);
        bit no_room;
        bit bad_key;
        bit complete;
        no_room = (capacity_reg == 0);
        bad_key = key_rejected();
        complete = still_match && (match_pos == key_len_reg);
        emits = 1'b0;
        res.value_byte = 8'h00;
        res.is_final = 1'b0;
        res.status = ST_FOUND;
        if (b == CHAR_NUL)
        begin
            if (parse_phase == P_KEY && complete)
                found = 1'b1;
            emits = 1'b1;
            res.is_final = 1'b1;
            if (no_room)
                res.status = ST_NO_ROOM;
            else if (bad_key)
                res.status = ST_BAD_KEY;
            else
                res.status = found ? ST_FOUND : ST_NOT_FOUND;
            parse_phase = P_START;
            match_pos = 0;
            still_match = 1'b1;
            copied = 0;
            found = 1'b0;
        end
        else
        begin
            case (parse_phase)
                P_START:
                begin
                    parse_phase = (b == CHAR_BACKSLASH) ? P_KEY : P_DONE;
                    match_pos = 0;
                    still_match = 1'b1;
                end
                P_KEY:
                begin
                    if (b == CHAR_BACKSLASH)
                    begin
                        if (complete)
                        begin
                            found = 1'b1;
                            copied = 0;
                            parse_phase = P_VCOPY;
                        end
                        else
                            parse_phase = P_VSKIP;
                    end
                    else if (still_match && match_pos < key_len_reg && match_pos < KEY_MAX_BYTES
                             && b == key_char(match_pos))
                        match_pos++;
                    else
                        still_match = 1'b0;
                end
                P_VSKIP:
                begin
                    if (b == CHAR_BACKSLASH)
                    begin
                        parse_phase = P_KEY;
                        match_pos = 0;
                        still_match = 1'b1;
                    end
                end
                P_VCOPY:
                begin
                    if (b == CHAR_BACKSLASH)
                        parse_phase = P_DONE;
                    else if (!no_room && !bad_key && copied + 1 < capacity_reg)
                    begin
                        copied++;
                        emits = 1'b1;
                        res.value_byte = b;
                    end
                end
                default:
                    ;
            endcase
        end
    endtask

    // Valid is only lowered during an idle gap, so back-to-back items never
    // see two assignments to in_valid in one step.
    task automatic send_byte(input logic [7:0] b, input bit pinned, input status_t pinned_status);
        bit      emits;
        result_t res;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        text_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        parse_text_byte(b, emits, res);
        if (emits)
        begin
            if (pinned && res.is_final)
                res.status = pinned_status;
            pending_lookup_results.push_back(res);
        end
        sent_bytes++;
    endtask

    task automatic send_key_field();
        int choice;
        int n;
        int spot;
        choice = $urandom_range(0, 6);
        n = (key_len_reg > KEY_MAX_BYTES) ? KEY_MAX_BYTES : key_len_reg;
        spot = $urandom_range(0, 15);
        case (choice)
            0, 1, 2:
                for (int i = 0; i < n; i++)
                    send_byte(key_char(i), 1'b0, ST_FOUND);
            3:
                for (int i = 0; i < n - 1; i++)
                    send_byte(key_char(i), 1'b0, ST_FOUND);
            4:
            begin
                for (int i = 0; i < n; i++)
                    send_byte(key_char(i), 1'b0, ST_FOUND);
                send_byte(field_char(), 1'b0, ST_FOUND);
            end
            5:
                for (int i = 0; i < n; i++)
                    send_byte((i == spot) ? key_char(i) ^ 8'($urandom_range(1, 255)) : key_char(i),
                              1'b0, ST_FOUND);
            default:
                repeat ($urandom_range(0, 4))
                    send_byte(field_char(), 1'b0, ST_FOUND);
        endcase
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_KEY_LOW:  key_low_reg = data;
            CFG_KEY_HIGH: key_high_reg = data;
            CFG_KEY_LEN:  key_len_reg = data[4:0];
            default:      capacity_reg = data[7:0];
        endcase
    endtask

    task automatic configure(input logic [127:0] key, input logic [4:0] len, input logic [7:0] cap);
        write_reg(CFG_KEY_LOW, key[63:0]);
        write_reg(CFG_KEY_HIGH, key[127:64]);
        write_reg(CFG_KEY_LEN, {59'd0, len});
        write_reg(CFG_CAPACITY, {56'd0, cap});
        cfg_valid <= 1'b0;
    endtask

    // Holds the sender off until every expected result is in, then lets the
    // output register drain before anything else happens.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_lookup_results.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_lookup_results.size() == 0)
            begin
                $error("unexpected result: value_byte %0h is_final %0b status %0d",
                       value_byte, is_final, status);
                mismatches++;
            end
            else
            begin
                oldest = pending_lookup_results.pop_front();
                if (value_byte !== oldest.value_byte)
                begin
                    $error("value_byte: expected %0h, got %0h", oldest.value_byte, value_byte);
                    mismatches++;
                end
                if (is_final !== oldest.is_final)
                begin
                    $error("is_final: expected %0b, got %0b", oldest.is_final, is_final);
                    mismatches++;
                end
                if (status !== oldest.status)
                begin
                    $error("status: expected %0d, got %0d", oldest.status, status);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        directed_string_t cur;
        logic [127:0]     key_word;
        logic [4:0]       len;
        logic [7:0]       cap;
        logic [7:0]       c;
        int               flavor;
        int               spot;
        int               mark;
        int               shape;
        int               n;

        // Reset registers first (key length 0), then no room taking precedence
        // over a bad key, bad keys of each kind, and parsing corner cases.
        directed_rows[0] = '{1'b0, 128'h0, 5'd0, 8'd1, 64'h0, ST_BAD_KEY};
        directed_rows[1] = '{1'b1, 128'h0, 5'd0, 8'd0, 64'h0, ST_NO_ROOM};
        directed_rows[2] = '{1'b1, 128'h5C, 5'd1, 8'd255, 64'h0, ST_BAD_KEY};
        directed_rows[3] = '{1'b1, 128'h2261, 5'd2, 8'd255, 64'h0, ST_BAD_KEY};
        directed_rows[4] = '{1'b1, 128'h61, 5'd17, 8'd255, 64'h0, ST_BAD_KEY};
        // Empty key and value fields before the match; 0xFF fits, 'y' is cut off.
        directed_rows[5] = '{1'b1, 128'h61, 5'd1, 8'd2, "\\\\\\a\\\377y\\", ST_FOUND};
        directed_rows[6] = '{1'b0, 128'h0, 5'd0, 8'd0, "x\\a", ST_NOT_FOUND};
        directed_rows[7] = '{1'b0, 128'h0, 5'd0, 8'd0, 64'h0, ST_NOT_FOUND};
        directed_rows[8] = '{1'b0, 128'h0, 5'd0, 8'd0, "\\a", ST_FOUND};
        // A zero key byte can never be matched.
        directed_rows[9] = '{1'b1, 128'h0, 5'd1, 8'd255, "\\", ST_NOT_FOUND};

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int row = 0; row < 10; row++)
        begin
            cur = directed_rows[row];
            if (cur.write_cfg)
            begin
                settle();
                configure(cur.key, cur.key_len, cur.capacity);
            end
            for (int i = 7; i >= 0; i--)
            begin
                if (cur.text[i * 8 +: 8] != CHAR_NUL)
                    send_byte(cur.text[i * 8 +: 8], 1'b0, ST_FOUND);
            end
            send_byte(CHAR_NUL, 1'b1, cur.outcome);
        end

        for (int stage = 0; stage < 3; stage++)
        begin
            send_idle_pct = (stage == 0) ? 22 : (stage == 1) ? 46 : 0;
            recv_idle_pct = (stage == 0) ? 46 : (stage == 1) ? 22 : 0;
            for (int setting = 0; setting < SETTINGS_PER_STAGE; setting++)
            begin
                for (int i = 0; i < KEY_MAX_BYTES; i++)
                begin
                    do
                        c = field_char();
                    while (c == CHAR_DQUOTE);
                    key_word[i * 8 +: 8] = c;
                end
                flavor = $urandom_range(0, 9);
                len = 5'($urandom_range(1, KEY_MAX_BYTES));
                case ($urandom_range(0, 7))
                    0:       cap = 8'd0;
                    1:       cap = 8'd1;
                    2:       cap = 8'd255;
                    3:       cap = 8'd2;
                    default: cap = 8'($urandom_range(3, 12));
                endcase
                if (setting == 0)
                begin
                    len = 5'd16;
                    cap = 8'd255;
                end
                else if (setting == 1)
                begin
                    len = 5'd1;
                    cap = 8'd1;
                end
                else
                begin
                    spot = $urandom_range(0, len - 1);
                    if (flavor == 0)
                        key_word[spot * 8 +: 8] = $urandom_range(0, 1) ? CHAR_BACKSLASH : CHAR_DQUOTE;
                    else if (flavor == 1)
                        key_word[spot * 8 +: 8] = CHAR_NUL;
                    else if (flavor == 2)
                        len = 5'd0;
                end
                settle();
                configure(key_word, len, cap);

                mark = sent_bytes;
                while (sent_bytes - mark < BYTES_PER_SETTING)
                begin
                    shape = $urandom_range(0, 9);
                    if (shape == 0)
                    begin
                        repeat ($urandom_range(0, 10))
                            send_byte(8'($urandom_range(1, 255)), 1'b0, ST_FOUND);
                    end
                    else if (shape == 1)
                    begin
                        // Missing leading separator: everything up to the zero byte is ignored.
                        send_byte(field_char(), 1'b0, ST_FOUND);
                        send_key_field();
                        send_byte(CHAR_BACKSLASH, 1'b0, ST_FOUND);
                    end
                    else
                    begin
                        repeat ($urandom_range(1, 4))
                        begin
                            send_byte(CHAR_BACKSLASH, 1'b0, ST_FOUND);
                            send_key_field();
                            send_byte(CHAR_BACKSLASH, 1'b0, ST_FOUND);
                            if (capacity_reg >= 8'd200 && $urandom_range(0, 9) == 0)
                                n = $urandom_range(250, 258);
                            else
                                n = $urandom_range(0, 5);
                            repeat (n)
                                send_byte(field_char(), 1'b0, ST_FOUND);
                        end
                        // Sometimes the string ends inside a key field.
                        if ($urandom_range(0, 3) == 0)
                        begin
                            send_byte(CHAR_BACKSLASH, 1'b0, ST_FOUND);
                            send_key_field();
                        end
                    end
                    send_byte(CHAR_NUL, 1'b0, ST_FOUND);
                end
            end
        end

        settle();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ infostring_key_lookup_top.f @@
rtl/core/iskl_pkg.sv
rtl/core/infostring_key_lookup_top.sv
rtl/core/iskl_checker.sv
sim/tb_infostring_key_lookup_top.sv
